[hw/rtl/chee_pkg.sv]
// ----------------------------------------------------------------------------
// chee_pkg
// Shared types and constants for the cluster head election engine.
// ----------------------------------------------------------------------------
package chee_pkg;

  // input actions
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_ADV   = 3'd1;
  localparam logic [2:0] ACT_ACK   = 3'd2;
  localparam logic [2:0] ACT_SCHED = 3'd3;
  localparam logic [2:0] ACT_DATA  = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_ADV    = 3'd0;
  localparam logic [2:0] KIND_ACK    = 3'd1;
  localparam logic [2:0] KIND_SCHED  = 3'd2;
  localparam logic [2:0] KIND_DATA   = 3'd3;
  localparam logic [2:0] KIND_REPORT = 3'd4;

  // register indexes
  localparam logic [2:0] REG_SELF  = 3'd0;
  localparam logic [2:0] REG_FRAC  = 3'd1;
  localparam logic [2:0] REG_EPOCH = 3'd2;
  localparam logic [2:0] REG_MINM  = 3'd3;
  localparam logic [2:0] REG_BASE  = 3'd4;

  localparam logic [31:0] BCAST_ADDR   = 32'hFFFF_FFFF;
  localparam logic [31:0] BASE_RESET   = 32'h0A00_0001;
  localparam logic [15:0] FRAC_RESET   = 16'd3277;
  localparam logic [7:0]  EPOCH_RESET  = 8'd20;
  localparam logic [6:0]  MINM_RESET   = 7'd2;
  // schedule transactions per ack are capped at this many entries
  localparam logic [6:0]  MAX_OUT      = 7'd64;
  localparam logic [6:0]  SLOT_MAX     = 7'd127;

  typedef struct packed {
    logic [31:0] self_addr;
    logic [15:0] head_fraction_q16;
    logic [7:0]  epoch_rounds;
    logic [6:0]  min_members;
    logic [31:0] base_station_addr;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  msg_kind;
    logic [31:0] dest_addr;
    logic [31:0] member_addr;
    logic [6:0]  slot_delay;
    logic        last_result;
  } res_t;

endpackage

[hw/rtl/chee_if.sv]
// ----------------------------------------------------------------------------
// chee_in_if / chee_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface chee_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] src_addr;
  logic [15:0] rx_power;
  logic [15:0] rand_value;
  logic [31:0] entry_addr;
  logic [6:0]  entry_slot;
  logic        entry_last;

  modport source (output valid, action, src_addr, rx_power, rand_value, entry_addr,
                  entry_slot, entry_last, input ready);
  modport sink   (input valid, action, src_addr, rx_power, rand_value, entry_addr,
                  entry_slot, entry_last, output ready);
  modport mon    (input valid, ready, action, src_addr, rx_power, rand_value,
                  entry_addr, entry_slot, entry_last);
endinterface

interface chee_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  msg_kind;
  logic [31:0] dest_addr;
  logic [31:0] member_addr;
  logic [6:0]  slot_delay;
  logic        last_result;

  modport source (output valid, msg_kind, dest_addr, member_addr, slot_delay,
                  last_result, input ready);
  modport sink   (input valid, msg_kind, dest_addr, member_addr, slot_delay,
                  last_result, output ready);
  modport mon    (input valid, ready, msg_kind, dest_addr, member_addr, slot_delay,
                  last_result);
endinterface

[hw/rtl/cluster_head_election_engine_unit.sv]
// ----------------------------------------------------------------------------
// cluster_head_election_engine_unit
// Per-node cluster head protocol engine: election, head/member tables, TDMA
// schedule broadcast and data/report transactions.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  in_if   | in  | valid/ready      | action, addresses, power, rand, entry
//  out_if  | out | valid/ready      | kind, dest, member, slot, last
//  cfg_*   | in  | APB, pready high | five config registers
//
// One item at a time. A tick runs an 8-step remainder, two multiplies and a
// decide step. Ad items, ack items at a head and last schedule items scan their
// table at one entry per cycle through the RAM read port. A schedule broadcast
// reads, then loads each entry. Tables reset by counts, no clearing pass. Result
// stalls hold the engine at the output register; in_ready is low until idle.
module cluster_head_election_engine_unit #(
  parameter int MAX_NODES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  chee_in_if.sink     in_if,
  chee_out_if.source  out_if
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int WW = (CW > 7) ? CW : 7;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV  = 8'b0000_0010,
    S_MUL1 = 8'b0000_0100,
    S_MUL2 = 8'b0000_1000,
    S_CMP  = 8'b0001_0000,
    S_SCAN = 8'b0010_0000,
    S_ERD  = 8'b0100_0000,
    S_EWR  = 8'b1000_0000
  } state_t;

  chee_pkg::cfg_t cfg;

  chee_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cfg(cfg)
  );

  // control state
  state_t        state_r, state_nxt;
  logic [7:0]    phase_r, phase_nxt;
  logic          was_head_r, was_head_nxt, is_head_r, is_head_nxt;
  logic [CW-1:0] hc_r, hc_nxt, mc_r, mc_nxt;
  logic [6:0]    own_slot_r, own_slot_nxt;
  logic          osv_r, osv_nxt;
  logic          out_valid_r;
  // working registers
  logic [2:0]    act_r, act_nxt;
  logic [31:0]   src_r, src_nxt;
  logic [15:0]   pwr_r, pwr_nxt, rnd_r, rnd_nxt;
  logic [7:0]    dvd_r, dvd_nxt, rem_r, rem_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [23:0]   prod_r, prod_nxt;
  logic [32:0]   mul_r, mul_nxt;
  logic          dz_r, dz_nxt, dn_r, dn_nxt;
  logic [CW-1:0] iss_r, iss_nxt, ei_r, ei_nxt, en_r, en_nxt;
  logic          pend_r, pend_nxt, found_r, found_nxt, sel_head_r, sel_head_nxt;
  logic [15:0]   bpw_r, bpw_nxt;
  logic [31:0]   baddr_r, baddr_nxt;
  chee_pkg::res_t out_r, ld_res;
  logic          ld;

  // memories
  logic          h_we, m_we, h_re, m_re;
  logic [IW-1:0] raddr;
  logic [47:0]   h_rdata;
  logic [31:0]   m_rdata;

  chee_ram #(.W(48), .DEPTH(MAX_NODES)) u_head_ram (
    .clk(clk), .we(h_we), .waddr(hc_r[IW-1:0]), .wdata({src_r, pwr_r}),
    .re(h_re), .raddr(raddr), .rdata_r(h_rdata)
  );

  chee_ram #(.W(32), .DEPTH(MAX_NODES)) u_member_ram (
    .clk(clk), .we(m_we), .waddr(mc_r[IW-1:0]), .wdata(src_r),
    .re(m_re), .raddr(raddr), .rdata_r(m_rdata)
  );

  logic          out_free;
  logic [8:0]    rem_sh;
  logic [16:0]   d17;
  logic          hit;
  logic [CW-1:0] scan_cnt;
  logic [31:0]   rd_addr;
  logic [WW:0]   rep_slot;
  logic          osv_in;

  assign out_free    = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign rem_sh      = {rem_r, dvd_r[7]};
  assign d17         = 17'h10000 - {1'b0, prod_r[15:0]};
  assign scan_cnt    = sel_head_r ? hc_r : mc_r;
  assign rd_addr     = sel_head_r ? h_rdata[47:16] : m_rdata;
  assign rep_slot    = (WW + 1)'(mc_r) + (WW + 1)'(1);
  assign osv_in      = osv_r || (in_if.entry_addr == cfg.self_addr);
  assign hit         = dz_r ? 1'b1 : (dn_r ? 1'b0 :
                       (mul_r < {1'b0, cfg.head_fraction_q16, 16'd0}));

  // main sequencer
  always_comb begin
    state_nxt = state_r; phase_nxt = phase_r; was_head_nxt = was_head_r;
    is_head_nxt = is_head_r; hc_nxt = hc_r; mc_nxt = mc_r;
    own_slot_nxt = own_slot_r; osv_nxt = osv_r; act_nxt = act_r; src_nxt = src_r;
    pwr_nxt = pwr_r; rnd_nxt = rnd_r; dvd_nxt = dvd_r; rem_nxt = rem_r;
    step_nxt = step_r; prod_nxt = prod_r; mul_nxt = mul_r; dz_nxt = dz_r;
    dn_nxt = dn_r; iss_nxt = iss_r; ei_nxt = ei_r; en_nxt = en_r; pend_nxt = 1'b0;
    found_nxt = found_r; sel_head_nxt = sel_head_r; bpw_nxt = bpw_r;
    baddr_nxt = baddr_r;
    h_we = 1'b0; m_we = 1'b0; h_re = 1'b0; m_re = 1'b0; raddr = iss_r[IW-1:0];
    ld = 1'b0;
    ld_res = '{chee_pkg::KIND_ADV, chee_pkg::BCAST_ADDR, 32'd0, 7'd0, 1'b1};

    unique case (state_r)
      S_IDLE: begin
        iss_nxt = '0; found_nxt = 1'b0; bpw_nxt = '0;
        baddr_nxt = in_if.src_addr;
        if (in_if.valid) begin
          act_nxt = in_if.action; src_nxt = in_if.src_addr;
          pwr_nxt = in_if.rx_power; rnd_nxt = in_if.rand_value;
          case (in_if.action)
            chee_pkg::ACT_TICK: begin
              dvd_nxt = phase_r; rem_nxt = '0; step_nxt = '0; state_nxt = S_DIV;
            end
            chee_pkg::ACT_ADV: begin
              sel_head_nxt = 1'b1; state_nxt = S_SCAN;
            end
            chee_pkg::ACT_ACK: begin
              sel_head_nxt = 1'b0;
              if (is_head_r) state_nxt = S_SCAN;
            end
            chee_pkg::ACT_SCHED: begin
              sel_head_nxt = 1'b1;
              if (!osv_r && in_if.entry_addr == cfg.self_addr) begin
                own_slot_nxt = in_if.entry_slot; osv_nxt = 1'b1;
              end
              if (in_if.entry_last && osv_in) state_nxt = S_SCAN;
            end
            chee_pkg::ACT_DATA: begin
              // report slot saturates; waits for output register
              is_head_nxt = 1'b0;
              state_nxt   = S_EWR;
              ei_nxt = '0; en_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      // restoring remainder, one bit per cycle
      S_DIV: begin
        if (rem_sh >= {1'b0, cfg.epoch_rounds}) begin
          rem_nxt = 8'(rem_sh - {1'b0, cfg.epoch_rounds});
        end else begin
          rem_nxt = rem_sh[7:0];
        end
        dvd_nxt  = {dvd_r[6:0], 1'b0};
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) state_nxt = S_MUL1;
      end

      S_MUL1: begin
        prod_nxt  = (cfg.epoch_rounds == 8'd0) ? 24'd0 :
                    ({8'd0, cfg.head_fraction_q16} * {16'd0, rem_r});
        state_nxt = S_MUL2;
      end

      S_MUL2: begin
        dz_nxt    = (prod_r == 24'h01_0000);
        dn_nxt    = (prod_r > 24'h01_0000);
        mul_nxt   = {17'd0, rnd_r} * {16'd0, d17};
        state_nxt = S_CMP;
      end

      // election decision and epoch roll
      S_CMP: begin
        if (out_free) begin
          if (hit && !was_head_r) begin
            was_head_nxt = 1'b1; is_head_nxt = 1'b1; ld = 1'b1;
          end
          if ({1'b0, phase_r} + 9'd1 >= {1'b0, cfg.epoch_rounds}) begin
            phase_nxt = '0; was_head_nxt = 1'b0;
            hc_nxt = '0; mc_nxt = '0; own_slot_nxt = '0; osv_nxt = 1'b0;
          end else begin
            phase_nxt = phase_r + 8'd1;
          end
          state_nxt = S_IDLE;
        end
      end

      // linear table scan, one read issued per cycle
      S_SCAN: begin
        if (iss_r < scan_cnt) begin
          h_re = sel_head_r; m_re = !sel_head_r;
          iss_nxt = iss_r + CW'(1); pend_nxt = 1'b1;
        end
        if (pend_r) begin
          if (rd_addr == src_r) found_nxt = 1'b1;
          if (sel_head_r && h_rdata[15:0] > bpw_r) begin
            bpw_nxt = h_rdata[15:0]; baddr_nxt = rd_addr;
          end
        end
        if (iss_r == scan_cnt && !pend_r) begin
          if (act_r == chee_pkg::ACT_ADV) begin
            if (out_free) begin
              ld_res = '{chee_pkg::KIND_ACK, baddr_r, 32'd0, 7'd0, 1'b1};
              if (!found_r && hc_r < CW'(MAX_NODES)) begin
                h_we = 1'b1; hc_nxt = hc_r + CW'(1);
                if (pwr_r > bpw_r) ld_res.dest_addr = src_r;
              end
              ld = 1'b1; state_nxt = S_IDLE;
            end
          end else if (act_r == chee_pkg::ACT_SCHED) begin
            if (out_free) begin
              ld_res = '{chee_pkg::KIND_DATA, baddr_r, 32'd0, own_slot_r, 1'b1};
              ld = 1'b1; state_nxt = S_IDLE;
            end
          end else begin
            mc_nxt = mc_r;
            if (!found_r && mc_r < CW'(MAX_NODES)) begin
              m_we = 1'b1; mc_nxt = mc_r + CW'(1);
            end
            ei_nxt = '0;
            en_nxt = (WW'(mc_nxt) > WW'(chee_pkg::MAX_OUT)) ?
                     CW'(chee_pkg::MAX_OUT) : mc_nxt;
            state_nxt = (WW'(mc_nxt) > WW'(cfg.min_members)) ? S_ERD : S_IDLE;
          end
        end
      end

      // schedule broadcast: read entry
      S_ERD: begin
        m_re = 1'b1; raddr = ei_r[IW-1:0]; state_nxt = S_EWR;
      end

      // schedule entry or base report to the output register
      S_EWR: begin
        if (out_free) begin
          ld = 1'b1;
          if (act_r == chee_pkg::ACT_DATA) begin
            ld_res = '{chee_pkg::KIND_REPORT, cfg.base_station_addr, 32'd0,
                       (rep_slot > (WW + 1)'(chee_pkg::SLOT_MAX)) ?
                       chee_pkg::SLOT_MAX : rep_slot[6:0], 1'b1};
            state_nxt = S_IDLE;
          end else begin
            ld_res = '{chee_pkg::KIND_SCHED, chee_pkg::BCAST_ADDR, m_rdata,
                       7'(ei_r) + 7'd1, (ei_r + CW'(1) == en_r)};
            ei_nxt = ei_r + CW'(1);
            state_nxt = (ei_r + CW'(1) == en_r) ? S_IDLE : S_ERD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; phase_r <= '0; was_head_r <= 1'b0; is_head_r <= 1'b0;
      hc_r <= '0; mc_r <= '0; own_slot_r <= '0; osv_r <= 1'b0; pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; phase_r <= phase_nxt; was_head_r <= was_head_nxt;
      is_head_r <= is_head_nxt; hc_r <= hc_nxt; mc_r <= mc_nxt;
      own_slot_r <= own_slot_nxt; osv_r <= osv_nxt; pend_r <= pend_nxt;
      if (ld) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r <= act_nxt; src_r <= src_nxt; pwr_r <= pwr_nxt; rnd_r <= rnd_nxt;
    dvd_r <= dvd_nxt; rem_r <= rem_nxt; step_r <= step_nxt; prod_r <= prod_nxt;
    mul_r <= mul_nxt; dz_r <= dz_nxt; dn_r <= dn_nxt; iss_r <= iss_nxt;
    ei_r <= ei_nxt; en_r <= en_nxt; found_r <= found_nxt;
    sel_head_r <= sel_head_nxt; bpw_r <= bpw_nxt; baddr_r <= baddr_nxt;
    if (ld) out_r <= ld_res;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.msg_kind    = out_r.msg_kind;
  assign out_if.dest_addr   = out_r.dest_addr;
  assign out_if.member_addr = out_r.member_addr;
  assign out_if.slot_delay  = out_r.slot_delay;
  assign out_if.last_result = out_r.last_result;

endmodule

[hw/rtl/chee_ram.sv]
// ----------------------------------------------------------------------------
// chee_ram
// Single-port-write, single-port-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module chee_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata_r
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

[hw/rtl/chee_cfg.sv]
// ----------------------------------------------------------------------------
// chee_cfg
// APB register bank holding the node configuration.
// ----------------------------------------------------------------------------
module chee_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output chee_pkg::cfg_t    cfg
);

  chee_pkg::cfg_t cfg_r, cfg_nxt;
  logic [2:0]     idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (idx)
        chee_pkg::REG_SELF:  cfg_nxt.self_addr         = pwdata;
        chee_pkg::REG_FRAC:  cfg_nxt.head_fraction_q16 = pwdata[15:0];
        chee_pkg::REG_EPOCH: cfg_nxt.epoch_rounds      = pwdata[7:0];
        chee_pkg::REG_MINM:  cfg_nxt.min_members       = pwdata[6:0];
        chee_pkg::REG_BASE:  cfg_nxt.base_station_addr = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.self_addr         <= '0;
      cfg_r.head_fraction_q16 <= chee_pkg::FRAC_RESET;
      cfg_r.epoch_rounds      <= chee_pkg::EPOCH_RESET;
      cfg_r.min_members       <= chee_pkg::MINM_RESET;
      cfg_r.base_station_addr <= chee_pkg::BASE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read decode
  always_comb begin
    unique case (idx)
      chee_pkg::REG_SELF:  prdata = cfg_r.self_addr;
      chee_pkg::REG_FRAC:  prdata = {16'd0, cfg_r.head_fraction_q16};
      chee_pkg::REG_EPOCH: prdata = {24'd0, cfg_r.epoch_rounds};
      chee_pkg::REG_MINM:  prdata = {25'd0, cfg_r.min_members};
      chee_pkg::REG_BASE:  prdata = cfg_r.base_station_addr;
      default:             prdata = '0;
    endcase
  end

endmodule

[hw/rtl/chee_checker.sv]
// ----------------------------------------------------------------------------
// chee_checker
// Port-level checks for the election engine, bound to the top level.
// ----------------------------------------------------------------------------
module chee_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [31:0] out_dest,
  input logic [31:0] out_member,
  input logic [6:0]  out_slot,
  input logic        out_last
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result transaction keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_kind) && $stable(out_dest) && $stable(out_member) &&
      $stable(out_slot) && $stable(out_last))
    else $error("result payload changed while stalled");

  // only schedule entries may be non-final or carry a member
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != chee_pkg::KIND_SCHED |->
      out_last && out_member == 32'd0)
    else $error("non-schedule result not final");

  // advertisements are broadcast with zero delay
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == chee_pkg::KIND_ADV |->
      out_dest == chee_pkg::BCAST_ADDR && out_slot == 7'd0)
    else $error("bad advertisement");

endmodule

bind cluster_head_election_engine_unit chee_checker u_chee_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_kind(out_if.msg_kind),
  .out_dest(out_if.dest_addr), .out_member(out_if.member_addr),
  .out_slot(out_if.slot_delay), .out_last(out_if.last_result)
);
